// ===== rtl/ifpd_pkg.sv =====
// shared types and constants for the imu frame pair decoder
// no dependencies

package ifpd_pkg;

  localparam int PAIR_LEN  = 22;
  localparam int HALF_LEN  = PAIR_LEN / 2;
  localparam int FILL_W    = $clog2(PAIR_LEN + 1);
  localparam int RES_W     = 122;
  localparam int OUT_W     = 128;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // reciprocal of 85 scaled by 2^25, exact for dividends below 2^18
  localparam logic [18:0] RECIP_85    = 19'd394759;
  localparam int          RECIP_SHIFT = 25;
  localparam logic signed [12:0] TEMP_OFFSET = 13'sd580;

  typedef logic [PAIR_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic        [15:0] frame_count;
    logic signed [12:0] temperature;
    logic signed [14:0] yaw;
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic signed [15:0] gyro_z;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_x;
  } res_t;

endpackage

// ===== rtl/ifpd_window.sv =====
// byte window, fill count, sync match and pair counter
// depends on ifpd_pkg

module ifpd_window (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [7:0]                           in_byte,
  output logic                                 in_ready,
  input  logic                                 take,
  output logic                                 pend,
  output ifpd_pkg::win_t                       win,
  output logic [15:0]                          pair_cnt
);

  ifpd_pkg::win_t                    win_r;
  ifpd_pkg::win_t                    win_nxt;
  logic [ifpd_pkg::FILL_W-1:0]       fill_r;
  logic [ifpd_pkg::FILL_W-1:0]       fill_inc;
  logic                              pend_r;
  logic [15:0]                       pair_r;
  logic                              accept;
  logic                              hit;

  assign in_ready = !pend_r || take;
  assign accept   = in_valid && in_ready;
  assign win_nxt  = {in_byte, win_r[ifpd_pkg::PAIR_LEN-1:1]};

  always_comb begin
    if (fill_r < ifpd_pkg::FILL_W'(ifpd_pkg::PAIR_LEN)) begin
      fill_inc = fill_r + ifpd_pkg::FILL_W'(1);
    end else begin
      fill_inc = fill_r;
    end
  end

  assign hit = (fill_inc == ifpd_pkg::FILL_W'(ifpd_pkg::PAIR_LEN)) &&
               (win_nxt[0] == ifpd_pkg::SYNC_BYTE) &&
               (win_nxt[ifpd_pkg::HALF_LEN] == ifpd_pkg::SYNC_BYTE);

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
      pair_r <= '0;
    end else if (accept) begin
      fill_r <= hit ? '0 : fill_inc;
      pend_r <= hit;
      if (hit) begin
        pair_r <= pair_r + 16'd1;
      end
    end else if (take) begin
      pend_r <= 1'b0;
    end
  end

  assign pend     = pend_r;
  assign win      = win_r;
  assign pair_cnt = pair_r;

endmodule

// ===== rtl/ifpd_decode.sv =====
// fixed point scaling of a matched frame pair into the result register
// depends on ifpd_pkg

module ifpd_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pend,
  input  ifpd_pkg::win_t       win,
  input  logic [15:0]          pair_cnt,
  output logic                 take,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ifpd_pkg::res_t       res
);

  localparam int HB = ifpd_pkg::HALF_LEN;

  ifpd_pkg::res_t      res_r;
  ifpd_pkg::res_t      res_nxt;
  logic                res_valid_r;

  logic signed [15:0]  raw_a [3];
  logic signed [15:0]  raw_b [4];
  logic signed [23:0]  prod_g [3];
  logic signed [21:0]  prod_r [3];
  logic                t_neg;
  logic [16:0]         t_mag;
  logic [18:0]         t_num;
  logic [37:0]         t_prod;
  logic [12:0]         t_quo;
  logic signed [12:0]  t_sgn;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      raw_a[k]  = $signed({win[3 + 2*k], win[2 + 2*k]});
      prod_g[k] = $signed({{8{raw_a[k][15]}}, raw_a[k]}) * 24'sd125;
    end
    for (int k = 0; k < 4; k++) begin
      raw_b[k] = $signed({win[HB + 3 + 2*k], win[HB + 2 + 2*k]});
    end
    for (int k = 0; k < 3; k++) begin
      prod_r[k] = $signed({{6{raw_b[k][15]}}, raw_b[k]}) * 22'sd45;
    end
  end

  // trunc toward zero of raw*4/85 on the magnitude, sign restored after
  always_comb begin
    t_neg  = raw_b[3][15];
    t_mag  = t_neg ? (17'd0 - {1'b1, raw_b[3]}) : {1'b0, raw_b[3]};
    t_num  = {t_mag, 2'b00};
    t_prod = 38'(t_num) * 38'(ifpd_pkg::RECIP_85);
    t_quo  = t_prod[ifpd_pkg::RECIP_SHIFT +: 13];
    t_sgn  = t_neg ? $signed(13'd0 - t_quo) : $signed(t_quo);
  end

  always_comb begin
    res_nxt.gyro_x      = prod_g[0][22:7];
    res_nxt.gyro_y      = prod_g[1][22:7];
    res_nxt.gyro_z      = prod_g[2][22:7];
    res_nxt.roll        = prod_r[0][21:7];
    res_nxt.pitch       = prod_r[1][21:7];
    res_nxt.yaw         = prod_r[2][21:7];
    res_nxt.temperature = t_sgn + ifpd_pkg::TEMP_OFFSET;
    res_nxt.frame_count = pair_cnt;
  end

  assign take = pend && (!res_valid_r || res_ready);

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/imu_frame_pair_decoder_unit.sv =====
// top level of the imu frame pair decoder
// depends on ifpd_pkg, ifpd_window and ifpd_decode
//
// usage:
//   in_*  channel carries one received serial byte per transaction.
//   out_* channel carries one decoded frame pair per transaction.
//   every byte shifts a 22 byte window; once 22 bytes have arrived since
//   reset or the last match and the oldest byte and the byte 11 places
//   later are both 0x55, the window is decoded into gyro rates, angles,
//   temperature and a wrapping pair count, and the fill count restarts.
//   bytes that complete no pair give no output transaction.
//   a matched pair is held in the window register, then taken into the
//   result register. throughput: one byte per cycle while in_tready is
//   high; the window register holds a matched pair until the result
//   register takes it, so in_tready drops only while a matched pair and
//   an unconsumed result are both waiting.
//   reset clears the fill count, the pair counter and both valid flags.
//   a stall on out_tready holds the result steady and backs up into
//   in_tready after at most one further matched pair.

module imu_frame_pair_decoder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // gyro_x, gyro_y, gyro_z, roll, pitch, yaw, temperature, frame_count, zero fill
  output logic [ifpd_pkg::OUT_W-1:0]  out_tdata
);

  ifpd_pkg::win_t  win;
  ifpd_pkg::res_t  res;
  logic            pend;
  logic            take;
  logic [15:0]     pair_cnt;

  ifpd_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_ready (in_tready),
    .take     (take),
    .pend     (pend),
    .win      (win),
    .pair_cnt (pair_cnt)
  );

  ifpd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .pend      (pend),
    .win       (win),
    .pair_cnt  (pair_cnt),
    .take      (take),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {(ifpd_pkg::OUT_W - ifpd_pkg::RES_W)'(0), res};

endmodule

// ===== tb/tb.sv =====
// testbench for imu_frame_pair_decoder_unit: serial byte stream in, decoded frame pairs out
// depends on ifpd_pkg and the decoder rtl; holds its own window decoder to predict results
`timescale 1ns / 100ps

module tb;

  localparam int IDLE_PCT   = 26;
  localparam int HOLD_CYC   = 400;
  localparam int STALL_LIM  = 5000;
  localparam int RAND_BYTES = 1150;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [ifpd_pkg::OUT_W-1:0] out_tdata;

  imu_frame_pair_decoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  logic [7:0]     byte_q[$];
  ifpd_pkg::res_t pair_q[$];
  int             bytes_sent = 0;
  int             pairs_seen = 0;
  int             err_cnt = 0;
  int             quiet_cyc = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;
  logic           calm;

  assign calm = bytes_sent >= 500 && bytes_sent < 700;

  // decoder state
  logic [7:0]  win [ifpd_pkg::PAIR_LEN];
  int          win_fill = 0;
  logic [15:0] pair_cnt = '0;

  initial begin
    for (int i = 0; i < ifpd_pkg::PAIR_LEN; i++) win[i] = '0;
  end

  function automatic int word_at(int base, int off);
    logic signed [15:0] w;
    w = {win[base+off+1], win[base+off]};
    return w;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    ifpd_pkg::res_t r;
    for (int i = 0; i < ifpd_pkg::PAIR_LEN - 1; i++) win[i] = win[i+1];
    win[ifpd_pkg::PAIR_LEN-1] = b;
    if (win_fill < ifpd_pkg::PAIR_LEN) win_fill++;
    if (win_fill == ifpd_pkg::PAIR_LEN && win[0] == ifpd_pkg::SYNC_BYTE &&
        win[ifpd_pkg::HALF_LEN] == ifpd_pkg::SYNC_BYTE) begin
      win_fill = 0;
      pair_cnt = pair_cnt + 16'd1;
      r.gyro_x      = 16'((word_at(0, 2) * 125) >>> 7);
      r.gyro_y      = 16'((word_at(0, 4) * 125) >>> 7);
      r.gyro_z      = 16'((word_at(0, 6) * 125) >>> 7);
      r.roll        = 15'((word_at(ifpd_pkg::HALF_LEN, 2) * 45) >>> 7);
      r.pitch       = 15'((word_at(ifpd_pkg::HALF_LEN, 4) * 45) >>> 7);
      r.yaw         = 15'((word_at(ifpd_pkg::HALF_LEN, 6) * 45) >>> 7);
      r.temperature = 13'((word_at(ifpd_pkg::HALF_LEN, 8) * 4) / 85 + 580);
      r.frame_count = pair_cnt;
      pair_q.push_back(r);
    end
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // wa/wb index 0..3: first three words then a fourth word, the temperature word in wb
  task automatic push_pair(input logic [3:0][15:0] wa, input logic [3:0][15:0] wb,
                           input int keep, input bit bad_sync);
    logic [7:0] f [ifpd_pkg::PAIR_LEN];
    for (int h = 0; h < 2; h++) begin
      f[h*ifpd_pkg::HALF_LEN]      = ifpd_pkg::SYNC_BYTE;
      f[h*ifpd_pkg::HALF_LEN + 1]  = 8'($urandom);
      f[h*ifpd_pkg::HALF_LEN + 10] = 8'($urandom);
      for (int k = 0; k < 4; k++) begin
        f[h*ifpd_pkg::HALF_LEN + 2 + 2*k] = h ? wb[k][7:0]  : wa[k][7:0];
        f[h*ifpd_pkg::HALF_LEN + 3 + 2*k] = h ? wb[k][15:8] : wa[k][15:8];
      end
    end
    if (bad_sync) begin
      f[ifpd_pkg::HALF_LEN] = 8'($urandom);
      if (f[ifpd_pkg::HALF_LEN] == ifpd_pkg::SYNC_BYTE) f[ifpd_pkg::HALF_LEN] = 8'hAA;
    end
    for (int i = 0; i < keep; i++) byte_q.push_back(f[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at pair %0d: %s", pairs_seen, msg);
    err_cnt++;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= byte_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && pairs_seen >= 10) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYC;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    ifpd_pkg::res_t got;
    ifpd_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pairs_seen <= pairs_seen + 1;
      got = ifpd_pkg::res_t'(out_tdata[ifpd_pkg::RES_W-1:0]);
      if (out_tdata[ifpd_pkg::OUT_W-1:ifpd_pkg::RES_W] !== '0)
        report_mismatch($sformatf("fill bits %h",
                                  out_tdata[ifpd_pkg::OUT_W-1:ifpd_pkg::RES_W]));
      if (pair_q.size() == 0) begin
        report_mismatch("transaction with no pair pending");
      end else begin
        want = pair_q.pop_front();
        if (got.gyro_x !== want.gyro_x)
          report_mismatch($sformatf("gyro_x %0d want %0d", got.gyro_x, want.gyro_x));
        if (got.gyro_y !== want.gyro_y)
          report_mismatch($sformatf("gyro_y %0d want %0d", got.gyro_y, want.gyro_y));
        if (got.gyro_z !== want.gyro_z)
          report_mismatch($sformatf("gyro_z %0d want %0d", got.gyro_z, want.gyro_z));
        if (got.roll !== want.roll)
          report_mismatch($sformatf("roll %0d want %0d", got.roll, want.roll));
        if (got.pitch !== want.pitch)
          report_mismatch($sformatf("pitch %0d want %0d", got.pitch, want.pitch));
        if (got.yaw !== want.yaw)
          report_mismatch($sformatf("yaw %0d want %0d", got.yaw, want.yaw));
        if (got.temperature !== want.temperature)
          report_mismatch($sformatf("temperature %0d want %0d",
                                    got.temperature, want.temperature));
        if (got.frame_count !== want.frame_count)
          report_mismatch($sformatf("frame_count %0d want %0d",
                                    got.frame_count, want.frame_count));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cyc <= 0;
      end else if (quiet_cyc >= STALL_LIM) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
    end
  end

  initial begin : stim
    int pick;
    // largest positive words in both frames
    push_pair({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
              {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, ifpd_pkg::PAIR_LEN, 1'b0);
    // most negative words
    push_pair({16'h8000, 16'h8000, 16'h8000, 16'h8000},
              {16'h8000, 16'h8000, 16'h8000, 16'h8000}, ifpd_pkg::PAIR_LEN, 1'b0);
    // small values around zero, temperature where truncation differs from floor
    push_pair({16'h1234, 16'h0001, 16'hFFFF, 16'h0000},
              {16'hFFEB, 16'h0000, 16'h0001, 16'hFFFF}, ifpd_pkg::PAIR_LEN, 1'b0);
    // solid sync bytes: one pair, then the cleared fill count blocks a quick rematch
    repeat (30) byte_q.push_back(ifpd_pkg::SYNC_BYTE);
    // second sync missing
    push_pair({pick_word(), pick_word(), pick_word(), pick_word()},
              {pick_word(), pick_word(), pick_word(), pick_word()},
              ifpd_pkg::PAIR_LEN, 1'b1);

    while (byte_q.size() < RAND_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        push_pair({pick_word(), pick_word(), pick_word(), pick_word()},
                  {pick_word(), pick_word(), pick_word(), pick_word()},
                  ifpd_pkg::PAIR_LEN, 1'b0);
      end else if (pick < 87) begin
        push_pair({pick_word(), pick_word(), pick_word(), pick_word()},
                  {pick_word(), pick_word(), pick_word(), pick_word()},
                  $urandom_range(1, ifpd_pkg::PAIR_LEN), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 8))
          byte_q.push_back(($urandom_range(0, 9) < 3) ? ifpd_pkg::SYNC_BYTE
                                                      : 8'($urandom));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() > 0 || in_tvalid) @(posedge clk);
    while (pair_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pair_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
